### hw/rtl/aes256c_pkg.sv
// Package for the AES-256 CTR keystream cipher: S-box, GF helpers, round function.
// No dependencies.
`timescale 1ns / 1ps
package aes256c_pkg;

    localparam int unsigned NUM_REGS = 6;
    localparam int unsigned ROUND_COUNT = 14;

    typedef enum logic [2:0] {
        REG_KEY0  = 3'd0,
        REG_KEY1  = 3'd1,
        REG_KEY2  = 3'd2,
        REG_KEY3  = 3'd3,
        REG_NONCEH = 3'd4,
        REG_NONCEL = 3'd5
    } t_reg_idx;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // State byte k (column-major) sits at bits [127-8k -: 8].
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] all;
        logic [127:0] o;
        for (int k = 0; k < 16; k++) b[k] = s[127 - 8*k -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[c*4 + r] = sbox(b[((c + r) % 4)*4 + r]);
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
                for (int r = 0; r < 4; r++)
                    b[c*4 + r] = t[c*4 + r] ^ all ^ xtime(t[c*4 + r] ^ t[c*4 + (r+1)%4]);
            end
            for (int k = 0; k < 16; k++) t[k] = b[k];
        end
        for (int k = 0; k < 16; k++) o[127 - 8*k -: 8] = t[k];
        return o;
    endfunction

endpackage

### hw/rtl/aes256_ctr_keystream_cipher.sv
// AES-256 CTR keystream cipher top level: config regs, key schedule, round loop.
// Depends on aes256c_pkg.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata = data_high, data_low, byte_count
//  m_axis    | out       | tdata = result_high, result_low
//  APB       | in/out    | six 64-bit registers at 8*i
//
// After reset or a register write the round-key schedule is rebuilt: one 32-bit
// word per cycle (eight key words, then 52 derived), during which no item is
// taken. An item then runs in one shared round unit (initial key add at the input
// transfer plus 14 rounds, round keys read in order from the store); the last
// round loads the output register. The next item may be taken while a result
// waits; its last round stalls until the output register is free.
// Reset is synchronous.
`timescale 1ns / 1ps
module aes256_ctr_keystream_cipher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] data_high, [127:64] data_low, [132:128] byte_count, rest zero
    input  logic [135:0] s_axis_tdata,
    input  logic         m_axis_tready,
    output logic         m_axis_tvalid,
    // [63:0] result_high, [127:64] result_low
    output logic [127:0] m_axis_tdata
);
    import aes256c_pkg::*;

    typedef enum logic [1:0] {ST_KEYEXP, ST_IDLE, ST_RUN} t_state;

    localparam logic [3:0] LAST_RND = 4'(ROUND_COUNT);

    t_state        r_state;
    logic [63:0]   r_key [4];
    logic [63:0]   r_nonce_h, r_nonce_l, r_ctr;
    logic [127:0]  r_rk [15];      // round key r, word 0 in the top bits
    logic [31:0]   r_win [8];      // last eight schedule words, r_win[7] newest
    logic [5:0]    r_wi;           // schedule word index
    logic [7:0]    r_rc;
    logic [127:0]  r_st, r_data;
    logic [4:0]    r_cnt;
    logic [3:0]    r_rnd;
    logic [127:0]  r_out;
    logic          r_ovalid;

    logic          wr_en;
    logic [2:0]    widx;
    logic          round_done;
    assign pready = 1'b1;
    assign widx   = paddr[5:3];
    assign wr_en  = psel && penable && pwrite && (widx <= REG_NONCEL);

    always_comb begin
        case (widx)
            REG_KEY0:   prdata = r_key[0];
            REG_KEY1:   prdata = r_key[1];
            REG_KEY2:   prdata = r_key[2];
            REG_KEY3:   prdata = r_key[3];
            REG_NONCEH: prdata = r_nonce_h;
            REG_NONCEL: prdata = r_nonce_l;
            default:    prdata = '0;
        endcase
    end

    // key schedule word step; the first eight words come straight from the key
    logic [31:0] prev, tw, neww, kword;
    always_comb begin
        prev  = r_win[7];
        kword = r_wi[0] ? r_key[r_wi[2:1]][31:0] : r_key[r_wi[2:1]][63:32];
        if (r_wi[2:0] == 3'd0)
            tw = {sbox(prev[23:16]) ^ r_rc, sbox(prev[15:8]), sbox(prev[7:0]),
                  sbox(prev[31:24])};
        else if (r_wi[2:0] == 3'd4)
            tw = {sbox(prev[31:24]), sbox(prev[23:16]), sbox(prev[15:8]), sbox(prev[7:0])};
        else
            tw = prev;
        neww = (r_wi < 6'd8) ? kword : (r_win[0] ^ tw);
    end

    logic [127:0] rk, rout;
    always_comb begin
        rk   = r_rk[r_rnd];
        rout = aes_round(r_st, r_rnd == LAST_RND) ^ rk;
    end

    logic [127:0] mask, ks;
    always_comb begin
        for (int k = 0; k < 16; k++)
            mask[127 - 8*k -: 8] = (k < r_cnt) ? 8'hff : 8'h00;
        ks = rout ^ r_data;
    end

    assign round_done = !wr_en && (r_state == ST_RUN) && (r_rnd == LAST_RND) &&
                        (!r_ovalid || m_axis_tready);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out[63:0], r_out[127:64]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_KEYEXP;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            r_nonce_h <= '0;
            r_nonce_l <= '0;
            r_ctr    <= '0;
            r_wi     <= 6'd0;
            r_rc     <= 8'h01;
            r_rnd    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (round_done) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (wr_en) begin
                case (widx)
                    REG_KEY0:   r_key[0] <= pwdata;
                    REG_KEY1:   r_key[1] <= pwdata;
                    REG_KEY2:   r_key[2] <= pwdata;
                    REG_KEY3:   r_key[3] <= pwdata;
                    REG_NONCEH: r_nonce_h <= pwdata;
                    REG_NONCEL: r_nonce_l <= pwdata;
                    default:    ;
                endcase
                r_ctr   <= '0;
                r_wi    <= 6'd0;
                r_rc    <= 8'h01;
                r_state <= ST_KEYEXP;
            end else begin
                case (r_state)
                    ST_KEYEXP: begin
                        r_rk[r_wi[5:2]][127 - 32*r_wi[1:0] -: 32] <= neww;
                        for (int j = 0; j < 7; j++) r_win[j] <= r_win[j+1];
                        r_win[7] <= neww;
                        if (r_wi[2:0] == 3'd0 && r_wi != 6'd0) r_rc <= xtime(r_rc);
                        if (r_wi == 6'd59) r_state <= ST_IDLE;
                        else r_wi <= r_wi + 6'd1;
                    end
                    ST_IDLE: begin
                        if (s_axis_tvalid && s_axis_tready) begin
                            r_st    <= {r_nonce_h, r_nonce_l ^ r_ctr} ^ r_rk[0];
                            r_data  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                            r_cnt   <= (s_axis_tdata[132:128] > 5'd16) ? 5'd16
                                                                       : s_axis_tdata[132:128];
                            r_ctr   <= r_ctr + 64'd1;
                            r_rnd   <= 4'd1;
                            r_state <= ST_RUN;
                        end
                    end
                    ST_RUN: begin
                        if (r_rnd != LAST_RND) begin
                            r_st  <= rout;
                            r_rnd <= r_rnd + 4'd1;
                        end else if (round_done) begin
                            r_out   <= ks & mask;
                            r_state <= ST_IDLE;
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end
endmodule
